/* design/fgb_pkg.sv */
// ----------------------------------------------------------------------------
// fgb_pkg
// Types, register codes and helpers shared by the face grid binning block.
// ----------------------------------------------------------------------------
package fgb_pkg;

    localparam int COORD_W = 24;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int GRID_W  = 7;
    localparam int PART_W  = 14;
    localparam int IDX_W   = 21;
    localparam int CNT_W   = 16;
    localparam int TILE_W  = 12;
    localparam int SH_W    = 5;
    localparam int CFG_AW  = 3;

    localparam logic [CFG_AW-1:0] CFG_ORIGIN_X    = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_ORIGIN_Y    = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_ORIGIN_Z    = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_TILE_SHIFT  = 3'd3;
    localparam logic [CFG_AW-1:0] CFG_GRID_WIDTH  = 3'd4;
    localparam logic [CFG_AW-1:0] CFG_GRID_HEIGHT = 3'd5;
    localparam logic [CFG_AW-1:0] CFG_GRID_DEPTH  = 3'd6;

    localparam logic [CNT_W-1:0] CNT_MAX = 16'hFFFF;

    typedef struct packed {
        logic signed [COORD_W-1:0] vert_x;
        logic signed [COORD_W-1:0] vert_y;
        logic signed [COORD_W-1:0] vert_z;
        logic                      is_sprite;
        logic                      last_vertex;
    } fgb_in_t;

    typedef struct packed {
        logic [TILE_W-1:0] tile_index;
        logic [CNT_W-1:0]  face_number;
        logic [CNT_W-1:0]  tile_faces;
        logic              index_overflow;
    } fgb_out_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] origin_x;
        logic signed [COORD_W-1:0] origin_y;
        logic signed [COORD_W-1:0] origin_z;
        logic [3:0]                tile_shift;
        logic [GRID_W-1:0]         grid_width;
        logic [GRID_W-1:0]         grid_height;
        logic [GRID_W-1:0]         grid_depth;
    } fgb_cfg_t;

    // Minimum corner of one finished face.
    typedef struct packed {
        logic signed [COORD_W-1:0] min_x;
        logic signed [COORD_W-1:0] min_y;
        logic signed [COORD_W-1:0] min_z;
        logic [CNT_W-1:0]          face_number;
    } fgb_corner_t;

    // Linear tile index of one face, ready for the counter update.
    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic [CNT_W-1:0] face_number;
    } fgb_tile_req_t;

    // A grid size of zero behaves as one.
    function automatic logic [GRID_W-1:0] eff_size(input logic [GRID_W-1:0] size);
        eff_size = (size == '0) ? GRID_W'(1) : size;
    endfunction

    // Floor the offset to a tile and clamp it to the grid; below the origin gives 0.
    function automatic logic [GRID_W-1:0] axis_tile(input logic signed [DIFF_W-1:0] diff,
                                                     input logic [SH_W-1:0] sh,
                                                     input logic [GRID_W-1:0] lim);
        logic [COORD_W-1:0] pos;
        pos = diff[COORD_W-1:0] >> sh;
        if (diff[DIFF_W-1])
            axis_tile = '0;
        else if (pos > {{(COORD_W-GRID_W){1'b0}}, lim})
            axis_tile = lim;
        else
            axis_tile = pos[GRID_W-1:0];
    endfunction

endpackage

/* design/fgb_ram.sv */
// ----------------------------------------------------------------------------
// fgb_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module fgb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* design/fgb_vertex_min.sv */
// ----------------------------------------------------------------------------
// fgb_vertex_min
// Per-axis minimum of a face's vertices (sprite: first only), face numbering.
// ----------------------------------------------------------------------------
module fgb_vertex_min
    import fgb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  fgb_in_t     in_data,
    input  logic        clr_busy,
    output logic        corner_valid,
    input  logic        corner_stall,
    output fgb_corner_t corner
);

    logic signed [COORD_W-1:0] min_x_reg, min_y_reg, min_z_reg;
    logic signed [COORD_W-1:0] min_x_next, min_y_next, min_z_next;
    logic                      start_reg;
    logic [CNT_W-1:0]          faces_reg;
    logic                      corner_vld_reg;
    fgb_corner_t               corner_reg;
    logic                      in_acc;
    logic                      keep_min;

    assign in_stall = clr_busy || (corner_vld_reg && corner_stall);
    assign in_acc   = in_valid && !in_stall;
    assign keep_min = !start_reg && in_data.is_sprite;

    always_comb
    begin
        if (start_reg)
        begin
            min_x_next = in_data.vert_x;
            min_y_next = in_data.vert_y;
            min_z_next = in_data.vert_z;
        end
        else if (keep_min)
        begin
            min_x_next = min_x_reg;
            min_y_next = min_y_reg;
            min_z_next = min_z_reg;
        end
        else
        begin
            min_x_next = (in_data.vert_x < min_x_reg) ? in_data.vert_x : min_x_reg;
            min_y_next = (in_data.vert_y < min_y_reg) ? in_data.vert_y : min_y_reg;
            min_z_next = (in_data.vert_z < min_z_reg) ? in_data.vert_z : min_z_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_x_reg      <= '0;
            min_y_reg      <= '0;
            min_z_reg      <= '0;
            start_reg      <= 1'b1;
            faces_reg      <= '0;
            corner_vld_reg <= 1'b0;
        end
        else
        begin
            if (in_acc)
            begin
                min_x_reg <= min_x_next;
                min_y_reg <= min_y_next;
                min_z_reg <= min_z_next;
                start_reg <= in_data.last_vertex;
            end
            if (in_acc && in_data.last_vertex)
            begin
                faces_reg      <= faces_reg + CNT_W'(1);
                corner_vld_reg <= 1'b1;
            end
            else if (!corner_stall)
            begin
                corner_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc && in_data.last_vertex)
        begin
            corner_reg.min_x       <= min_x_next;
            corner_reg.min_y       <= min_y_next;
            corner_reg.min_z       <= min_z_next;
            corner_reg.face_number <= faces_reg;
        end
    end

    assign corner_valid = corner_vld_reg;
    assign corner       = corner_reg;

    a_last_makes_corner: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && in_data.last_vertex |=> corner_vld_reg)
        else $error("finished face did not produce a corner");

    a_face_count: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && in_data.last_vertex |=> faces_reg == $past(faces_reg) + CNT_W'(1))
        else $error("face counter did not advance");

    a_no_input_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clr_busy |-> !in_acc)
        else $error("vertex taken during clearing pass");

endmodule

/* design/fgb_tile_calc.sv */
// ----------------------------------------------------------------------------
// fgb_tile_calc
// Pipeline from a face's minimum corner to its linear tile index.
// ----------------------------------------------------------------------------
module fgb_tile_calc
    import fgb_pkg::*;
#(
    parameter int COORD_FRAC_BITS = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  fgb_cfg_t      cfg,
    input  logic          corner_valid,
    output logic          corner_stall,
    input  fgb_corner_t   corner,
    output logic          req_valid,
    input  logic          req_stall,
    output fgb_tile_req_t req
);

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic adv1, adv2, adv3, adv4;

    logic signed [DIFF_W-1:0] dx_reg, dy_reg, dz_reg;
    logic [CNT_W-1:0]         face1_reg, face2_reg, face3_reg;
    logic [GRID_W-1:0]        tx_reg, ty_reg, tz_reg, tx3_reg;
    logic [PART_W-1:0]        part_reg;
    fgb_tile_req_t            req_reg;

    logic [GRID_W-1:0] w_eff, h_eff, d_eff;
    logic [SH_W-1:0]   sh;

    assign w_eff = eff_size(cfg.grid_width);
    assign h_eff = eff_size(cfg.grid_height);
    assign d_eff = eff_size(cfg.grid_depth);
    assign sh    = SH_W'(cfg.tile_shift) + SH_W'(COORD_FRAC_BITS);

    assign adv4 = !v4_reg || !req_stall;
    assign adv3 = !v3_reg || adv4;
    assign adv2 = !v2_reg || adv3;
    assign adv1 = !v1_reg || adv2;
    assign corner_stall = !adv1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (adv1) v1_reg <= corner_valid;
            if (adv2) v2_reg <= v1_reg;
            if (adv3) v3_reg <= v2_reg;
            if (adv4) v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1 && corner_valid)
        begin
            dx_reg    <= DIFF_W'(corner.min_x) - DIFF_W'(cfg.origin_x);
            dy_reg    <= DIFF_W'(corner.min_y) - DIFF_W'(cfg.origin_y);
            dz_reg    <= DIFF_W'(corner.min_z) - DIFF_W'(cfg.origin_z);
            face1_reg <= corner.face_number;
        end
        if (adv2 && v1_reg)
        begin
            tx_reg    <= axis_tile(dx_reg, sh, w_eff - GRID_W'(1));
            ty_reg    <= axis_tile(dy_reg, sh, h_eff - GRID_W'(1));
            tz_reg    <= axis_tile(dz_reg, sh, d_eff - GRID_W'(1));
            face2_reg <= face1_reg;
        end
        if (adv3 && v2_reg)
        begin
            // y*d*w + z*w + x is formed as (y*d + z)*w + x.
            part_reg  <= PART_W'(ty_reg) * PART_W'(d_eff) + PART_W'(tz_reg);
            tx3_reg   <= tx_reg;
            face3_reg <= face2_reg;
        end
        if (adv4 && v3_reg)
        begin
            req_reg.idx         <= IDX_W'(part_reg) * IDX_W'(w_eff) + IDX_W'(tx3_reg);
            req_reg.face_number <= face3_reg;
        end
    end

    assign req_valid = v4_reg;
    assign req       = req_reg;

    a_hold_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        v4_reg && req_stall |=> v4_reg && $stable(req_reg))
        else $error("tile request changed while stalled");

    a_tiles_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg |-> tx_reg < w_eff && ty_reg < h_eff && tz_reg < d_eff)
        else $error("tile coordinate outside grid");

    a_bubble_fills: assert property (@(posedge clk) disable iff (!rst_n)
        !v1_reg |-> !corner_stall)
        else $error("stall raised with empty first stage");

endmodule

/* design/fgb_count_update.sv */
// ----------------------------------------------------------------------------
// fgb_count_update
// Per-tile face counters in RAM: clearing pass, read-modify-write with
// forwarding, and the output register.
// ----------------------------------------------------------------------------
module fgb_count_update
    import fgb_pkg::*;
#(
    parameter int MAX_TILES = 4096
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  fgb_tile_req_t req,
    output logic          clr_busy,
    output logic          out_valid,
    input  logic          out_stall,
    output fgb_out_t      out_data
);

    localparam int AW = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_TILES - 1);

    logic          clr_reg;
    logic [AW-1:0] clr_cnt_reg;

    logic             v6_reg;
    logic [IDX_W-1:0] idx6_reg;
    logic             ovf6_reg;
    logic [CNT_W-1:0] face6_reg;

    logic          lw_vld_reg;
    logic [AW-1:0] lw_addr_reg;
    logic [CNT_W-1:0] lw_data_reg;

    logic     out_vld_reg;
    fgb_out_t out_reg;

    logic             adv_out, adv6, req_acc, ovf5, item_wr;
    logic             rd_en, wr_en;
    logic [AW-1:0]    wr_addr;
    logic [CNT_W-1:0] wr_data, rd_data, cur_cnt, new_cnt;

    assign ovf5    = 32'(req.idx) >= 32'(MAX_TILES);
    assign adv_out = !out_vld_reg || !out_stall;
    assign adv6    = !v6_reg || adv_out;
    assign req_stall = !adv6 || clr_reg;
    assign req_acc = req_valid && !req_stall;
    assign rd_en   = req_acc && !ovf5;
    assign item_wr = v6_reg && adv_out && !ovf6_reg;

    // The read for the next face can pass the write of the one before it.
    assign cur_cnt = (lw_vld_reg && lw_addr_reg == idx6_reg[AW-1:0]) ? lw_data_reg : rd_data;
    assign new_cnt = (cur_cnt == CNT_MAX) ? cur_cnt : cur_cnt + CNT_W'(1);

    assign wr_en   = clr_reg || item_wr;
    assign wr_addr = clr_reg ? clr_cnt_reg : idx6_reg[AW-1:0];
    assign wr_data = clr_reg ? '0 : new_cnt;

    fgb_ram #(
        .WIDTH (CNT_W),
        .DEPTH (MAX_TILES)
    ) u_counts (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (req.idx[AW-1:0]),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg     <= 1'b1;
            clr_cnt_reg <= '0;
            v6_reg      <= 1'b0;
            lw_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (clr_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == LAST_ADDR)
                begin
                    clr_reg <= 1'b0;
                end
            end
            if (adv6)
            begin
                v6_reg <= req_acc;
            end
            if (item_wr)
            begin
                lw_vld_reg <= 1'b1;
            end
            if (adv_out)
            begin
                out_vld_reg <= v6_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_acc)
        begin
            idx6_reg  <= req.idx;
            ovf6_reg  <= ovf5;
            face6_reg <= req.face_number;
        end
        if (item_wr)
        begin
            lw_addr_reg <= idx6_reg[AW-1:0];
            lw_data_reg <= new_cnt;
        end
        if (v6_reg && adv_out)
        begin
            out_reg.face_number    <= face6_reg;
            out_reg.index_overflow <= ovf6_reg;
            out_reg.tile_index     <= ovf6_reg ? '0 : idx6_reg[TILE_W-1:0];
            out_reg.tile_faces     <= ovf6_reg ? '0 : new_cnt;
        end
    end

    assign clr_busy  = clr_reg;
    assign out_valid = out_vld_reg;
    assign out_data  = out_reg;

    a_no_item_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clr_reg |-> !v6_reg && !out_vld_reg)
        else $error("face in flight during clearing pass");

    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && !out_reg.index_overflow |-> out_reg.tile_faces != '0)
        else $error("counted tile reports zero faces");

    a_overflow_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && out_reg.index_overflow |->
            out_reg.tile_faces == '0 && out_reg.tile_index == '0)
        else $error("overflow beat carries nonzero fields");

    a_fwd_same_tile: assert property (@(posedge clk) disable iff (!rst_n)
        item_wr ##1 (item_wr && idx6_reg == $past(idx6_reg) && $past(new_cnt) != CNT_MAX)
            |-> new_cnt == $past(new_cnt) + CNT_W'(1))
        else $error("back-to-back update of one tile lost a count");

endmodule

/* design/face_grid_binning.sv */
// ----------------------------------------------------------------------------
// face_grid_binning
// Bins faces into a uniform 3D tile grid by their minimum vertex corner and
// keeps a saturating face counter for every tile.
// ----------------------------------------------------------------------------
//  Channel  Handshake                 Payload     Beat
//  in       in_valid / in_stall       fgb_in_t    one vertex
//  out      out_valid / out_stall     fgb_out_t   one binned face
//  cfg      cfg_write                 cfg_addr,   one register write
//                                     cfg_data
//
// One vertex is taken every cycle while in_stall is low. A face's result passes
// through the corner register, four stages of tile arithmetic and the counter
// RAM read, then the output register. The last counter write is forwarded so
// faces on one tile may follow back to back. After reset a clearing pass zeroes
// the counter RAM, one entry a cycle, through all MAX_TILES entries; in_stall
// is high meanwhile.
// out_stall holds the pipeline stage by stage; empty stages keep filling.
// ----------------------------------------------------------------------------
module face_grid_binning
    import fgb_pkg::*;
#(
    parameter int MAX_TILES       = 4096,
    parameter int COORD_FRAC_BITS = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  fgb_in_t            in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output fgb_out_t           out_data,
    input  logic               cfg_write,
    input  logic [CFG_AW-1:0]  cfg_addr,
    input  logic [COORD_W-1:0] cfg_data
);

    fgb_cfg_t      cfg_reg;
    logic          clr_busy;
    logic          corner_valid, corner_stall;
    fgb_corner_t   corner;
    logic          req_valid, req_stall;
    fgb_tile_req_t req;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.origin_x    <= '0;
            cfg_reg.origin_y    <= '0;
            cfg_reg.origin_z    <= '0;
            cfg_reg.tile_shift  <= '0;
            cfg_reg.grid_width  <= GRID_W'(1);
            cfg_reg.grid_height <= GRID_W'(1);
            cfg_reg.grid_depth  <= GRID_W'(1);
        end
        else if (cfg_write)
        begin
            case (cfg_addr)
                CFG_ORIGIN_X:    cfg_reg.origin_x    <= cfg_data;
                CFG_ORIGIN_Y:    cfg_reg.origin_y    <= cfg_data;
                CFG_ORIGIN_Z:    cfg_reg.origin_z    <= cfg_data;
                CFG_TILE_SHIFT:  cfg_reg.tile_shift  <= cfg_data[3:0];
                CFG_GRID_WIDTH:  cfg_reg.grid_width  <= cfg_data[GRID_W-1:0];
                CFG_GRID_HEIGHT: cfg_reg.grid_height <= cfg_data[GRID_W-1:0];
                CFG_GRID_DEPTH:  cfg_reg.grid_depth  <= cfg_data[GRID_W-1:0];
                default: ;
            endcase
        end
    end

    fgb_vertex_min u_vertex_min (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_data      (in_data),
        .clr_busy     (clr_busy),
        .corner_valid (corner_valid),
        .corner_stall (corner_stall),
        .corner       (corner)
    );

    fgb_tile_calc #(
        .COORD_FRAC_BITS (COORD_FRAC_BITS)
    ) u_tile_calc (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .corner_valid (corner_valid),
        .corner_stall (corner_stall),
        .corner       (corner),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .req          (req)
    );

    fgb_count_update #(
        .MAX_TILES (MAX_TILES)
    ) u_count_update (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .clr_busy  (clr_busy),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule
